// ===== hw/rtl/bres_pkg.sv =====
// Shared constants for the Bresenham line generator.
// Used by bres_front, bres_back and bresenham_line_generator.
package bres_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_t;

endpackage

// ===== hw/rtl/bres_front.sv =====
// Front end: classifies incoming words and works out deltas, directions
// and the major axis of a start word. Depends on bres_pkg.
module bres_front #(
  parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
  input  logic                        mode,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic [4*COORD_BITS+3:0]      entry
);

  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS:0]   dx_neg;
  logic [COORD_BITS:0]   dy_neg;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  xneg;
  logic                  yneg;
  logic                  xmaj;
  logic                  is_step;

  always_comb begin
    dx      = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    dy      = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    dx_neg  = -dx;
    dy_neg  = -dy;
    xneg    = dx[COORD_BITS];
    yneg    = dy[COORD_BITS];
    adx     = xneg ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady     = yneg ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    xmaj    = adx > ady;
    is_step = (mode == bres_pkg::MODE_STEP);
    entry   = {is_step, xneg, yneg, xmaj, x_start, y_start,
               xmaj ? adx : ady, xmaj ? ady : adx};
  end

endmodule

// ===== hw/rtl/bres_queue.sv =====
// Short FIFO between front and back ends.
// Generic width and depth; no package dependency.
module bres_queue #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full   = (count == CW'(DEPTH));
  assign rvalid = (count != '0);
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/bres_back.sv =====
// Back end: line state, one output word per popped word, registered output.
// Depends on bres_pkg.
module bres_back #(
  parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [4*COORD_BITS+3:0]      q_entry,
  output logic                         q_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel,
  output logic                         no_pixel
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic          e_step;
  logic          e_xneg;
  logic          e_yneg;
  logic          e_xmaj;
  logic [CB-1:0] e_xs;
  logic [CB-1:0] e_ys;
  logic [CB-1:0] e_dmaj;
  logic [CB-1:0] e_dmin;

  logic [CB-1:0] current_x;
  logic [CB-1:0] current_y;
  logic [EW-1:0] error_term;
  logic [EW-1:0] err_diag;
  logic [EW-1:0] err_straight;
  logic [CB-1:0] steps_left;
  logic          x_negative;
  logic          y_negative;
  logic          x_is_major;
  logic          line_active;

  logic          pop;
  logic          diag;
  logic          move_x;
  logic          move_y;
  logic [CB-1:0] x_stepped;
  logic [CB-1:0] y_stepped;

  assign {e_step, e_xneg, e_yneg, e_xmaj, e_xs, e_ys, e_dmaj, e_dmin} = q_entry;

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    diag      = !error_term[EW-1];
    move_x    = x_is_major || diag;
    move_y    = !x_is_major || diag;
    x_stepped = current_x + (x_negative ? {CB{1'b1}} : CB'(1));
    y_stepped = current_y + (y_negative ? {CB{1'b1}} : CB'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      line_active <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (!e_step) begin
          line_active <= (e_dmaj != '0);
        end else if (line_active && steps_left == CB'(1)) begin
          line_active <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (!e_step) begin
        current_x    <= e_xs;
        current_y    <= e_ys;
        error_term   <= {1'b0, e_dmin, 1'b0} - {2'b00, e_dmaj};
        err_diag     <= {1'b0, e_dmin, 1'b0} - {1'b0, e_dmaj, 1'b0};
        err_straight <= {1'b0, e_dmin, 1'b0};
        steps_left   <= e_dmaj;
        x_negative   <= e_xneg;
        y_negative   <= e_yneg;
        x_is_major   <= e_xmaj;
        pixel_x      <= e_xs;
        pixel_y      <= e_ys;
        last_pixel   <= (e_dmaj == '0);
        no_pixel     <= 1'b0;
      end else if (!line_active) begin
        pixel_x    <= '0;
        pixel_y    <= '0;
        last_pixel <= 1'b0;
        no_pixel   <= 1'b1;
      end else begin
        if (move_x) begin
          current_x <= x_stepped;
        end
        if (move_y) begin
          current_y <= y_stepped;
        end
        error_term <= error_term + (diag ? err_diag : err_straight);
        steps_left <= steps_left - CB'(1);
        pixel_x    <= move_x ? x_stepped : current_x;
        pixel_y    <= move_y ? y_stepped : current_y;
        last_pixel <= (steps_left == CB'(1));
        no_pixel   <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/bresenham_line_generator.sv =====
// Bresenham line rasterizer, all octants; one result word per input word.
// Path: an accepted word is written into the queue, then into the back end's
// output register. Throughput: one word per cycle while out_ready stays high,
// set by the error update in the back end; a 2-entry queue decouples ends.
// Reset (rst, synchronous) empties the queue and output and ends any line.
module bresenham_line_generator #(
  parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel,
  output logic                         no_pixel
);

  localparam int ENTRY_W = 4 * COORD_BITS + 4;

  logic [ENTRY_W-1:0] f_entry;
  logic [ENTRY_W-1:0] q_entry;
  logic               q_full;
  logic               q_valid;
  logic               q_ready;
  logic               q_pop;

  assign in_ready = !q_full;
  assign q_pop    = q_valid && q_ready;

  bres_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .mode    (mode),
    .x_start (x_start),
    .x_end   (x_end),
    .y_start (y_start),
    .y_end   (y_end),
    .entry   (f_entry)
  );

  bres_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(bres_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (in_valid && in_ready),
    .wdata  (f_entry),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_entry)
  );

  bres_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_ready    (q_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel),
    .no_pixel   (no_pixel)
  );

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output or queue not empty after reset");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_pixel) |-> (pixel_x == '0 && pixel_y == '0 && !last_pixel))
    else $error("no_pixel word carries coordinates or last flag");

  a_queue_held: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready) |=> (q_valid && $stable(q_entry)))
    else $error("queue head changed while back end stalled");

endmodule
